// ----- hdl/rv32c_execute_unit_assert.svh -----
// assertion macros for the rv32c execute unit checker
// needs a clock named clk and an active-high reset named rst in scope
`ifndef RV32C_EXECUTE_UNIT_ASSERT_SVH
`define RV32C_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define RV32C_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rv32c execute unit assertion failed");

// next-cycle implication
`define RV32C_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rv32c execute unit assertion failed");

`endif

// ----- hdl/rv32c_pkg.sv -----
// types, codes and constants of the rv32c execute unit
// used by rv32c_execute_unit and its checker; no dependencies
`default_nettype none

package rv32c_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int IN_W      = 120;
  localparam int OUT_W     = 112;
  localparam logic [31:0] JR_MASK = ~32'd1;

  typedef enum logic [4:0] {
    OP_NOP   = 5'd0,
    OP_ADDI  = 5'd1,
    OP_LI    = 5'd2,
    OP_SRLI  = 5'd3,
    OP_SRAI  = 5'd4,
    OP_ANDI  = 5'd5,
    OP_SUB   = 5'd6,
    OP_XOR   = 5'd7,
    OP_OR    = 5'd8,
    OP_AND   = 5'd9,
    OP_SLLI  = 5'd10,
    OP_MV    = 5'd11,
    OP_ADD   = 5'd12,
    OP_LW    = 5'd13,
    OP_SW    = 5'd14,
    OP_J     = 5'd15,
    OP_JAL   = 5'd16,
    OP_BEQZ  = 5'd17,
    OP_BNEZ  = 5'd18,
    OP_JR    = 5'd19,
    OP_JALR  = 5'd20,
    OP_EBRK  = 5'd21,
    OP_FLW   = 5'd22,
    OP_FLD   = 5'd23,
    OP_FSW   = 5'd24,
    OP_FSD   = 5'd25
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_BREAK       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MK_NONE = 3'd0,
    MK_LW   = 3'd1,
    MK_SW   = 3'd2,
    MK_FLW  = 3'd3,
    MK_FLD  = 3'd4,
    MK_FSW  = 3'd5,
    MK_FSD  = 3'd6
  } mem_kind_t;

  localparam logic MODE_EXEC = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // first field in the highest bits
  typedef struct packed {
    logic               load_fault;
    logic [31:0]        load_value;
    logic [31:0]        pc_value;
    logic [2:0]         inst_length;
    logic signed [31:0] imm_value;
    logic [4:0]         src2_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         dest_reg;
    logic [4:0]         operation;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  fp_reg;
    logic [31:0] store_value;
    logic [31:0] mem_address;
    mem_kind_t   mem_kind;
    logic [31:0] jump_target;
    logic        jump_taken;
    status_t     status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/rv32c_execute_unit.sv -----
// rv32c execute unit: register file, operand read stage and result stage
// depends on rv32c_pkg
// One transfer is taken every cycle while input ready is high: on acceptance both source operands
// are read from the 32x32 register file (two registered read ports, newest write forwarded) into
// the operand stage; when that stage advances, the result is computed, written to the register
// file and loaded into the output register, which offers it on the output. Input ready drops only
// while both the operand stage and the output register hold a transfer and the output is stalled.
// Every register entry has a valid bit cleared by reset, so no clearing pass is needed.
`default_nettype none

module rv32c_execute_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // operation, dest_reg, src1_reg, src2_reg, imm_value, inst_length, pc_value,
  // load_value, load_fault
  input  wire logic [rv32c_pkg::IN_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic [0:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // status, jump_taken, jump_target, mem_kind, mem_address, store_value, fp_reg, zero pad
  output logic [rv32c_pkg::OUT_W-1:0]      m_axis_tdata
);
  import rv32c_pkg::*;

  logic [31:0]          regs [REG_COUNT];
  logic [REG_COUNT-1:0] reg_valid;

  in_item_t  in_item;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_mode;
  logic [31:0] s1_a;
  logic [31:0] s1_b;
  logic [4:0]  pending_load_dest;
  logic [4:0]  pending_load_dest_next;

  logic      out_valid;
  out_item_t out_item;
  out_item_t res;

  logic        s1_adv;
  logic        in_accept;
  logic        commit;
  logic        wb_req;
  logic [4:0]  wb_addr;
  logic [31:0] wb_data;
  logic        wr_en;
  logic [31:0] rd1_next;
  logic [31:0] rd2_next;

  logic [31:0] sum_ai;
  logic [31:0] sum_pi;
  logic [31:0] link;
  logic [4:0]  sh;

  function automatic logic reg_ok(input logic [4:0] idx);
    reg_ok = (idx != 5'd0) && ({1'b0, idx} < 6'(REG_COUNT));
  endfunction

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s1_adv        = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign commit        = s1_valid && s1_adv;
  assign wr_en         = commit && wb_req && reg_ok(wb_addr);

  // operand read with forwarding of the write in the same cycle
  always_comb begin
    if (!reg_ok(in_item.src1_reg)) begin
      rd1_next = '0;
    end else if (wr_en && wb_addr == in_item.src1_reg) begin
      rd1_next = wb_data;
    end else if (reg_valid[in_item.src1_reg[REG_AW-1:0]]) begin
      rd1_next = regs[in_item.src1_reg[REG_AW-1:0]];
    end else begin
      rd1_next = '0;
    end
    if (!reg_ok(in_item.src2_reg)) begin
      rd2_next = '0;
    end else if (wr_en && wb_addr == in_item.src2_reg) begin
      rd2_next = wb_data;
    end else if (reg_valid[in_item.src2_reg[REG_AW-1:0]]) begin
      rd2_next = regs[in_item.src2_reg[REG_AW-1:0]];
    end else begin
      rd2_next = '0;
    end
  end

  assign sum_ai = s1_a + s1_item.imm_value;
  assign sum_pi = s1_item.pc_value + s1_item.imm_value;
  assign link   = s1_item.pc_value + {29'd0, s1_item.inst_length};
  assign sh     = s1_item.imm_value[4:0];

  always_comb begin
    res                    = '0;
    wb_req                 = 1'b0;
    wb_addr                = s1_item.dest_reg;
    wb_data                = '0;
    pending_load_dest_next = pending_load_dest;
    if (s1_mode == MODE_LOAD) begin
      wb_req  = !s1_item.load_fault;
      wb_addr = pending_load_dest;
      wb_data = s1_item.load_value;
    end else begin
      case (op_t'(s1_item.operation))
        OP_NOP: begin
        end
        OP_ADDI: begin
          wb_req = 1'b1; wb_data = sum_ai;
        end
        OP_LI: begin
          wb_req = 1'b1; wb_data = s1_item.imm_value;
        end
        OP_SRLI: begin
          wb_req = 1'b1; wb_data = s1_a >> sh;
        end
        OP_SRAI: begin
          wb_req = 1'b1; wb_data = $unsigned($signed(s1_a) >>> sh);
        end
        OP_ANDI: begin
          wb_req = 1'b1; wb_data = s1_a & s1_item.imm_value;
        end
        OP_SUB: begin
          wb_req = 1'b1; wb_data = s1_a - s1_b;
        end
        OP_XOR: begin
          wb_req = 1'b1; wb_data = s1_a ^ s1_b;
        end
        OP_OR: begin
          wb_req = 1'b1; wb_data = s1_a | s1_b;
        end
        OP_AND: begin
          wb_req = 1'b1; wb_data = s1_a & s1_b;
        end
        OP_SLLI: begin
          wb_req = 1'b1; wb_data = s1_a << sh;
        end
        OP_MV: begin
          wb_req = 1'b1; wb_data = s1_b;
        end
        OP_ADD: begin
          wb_req = 1'b1; wb_data = s1_a + s1_b;
        end
        OP_LW: begin
          res.mem_kind = MK_LW; res.mem_address = sum_ai;
          pending_load_dest_next = s1_item.dest_reg;
        end
        OP_SW: begin
          res.mem_kind = MK_SW; res.mem_address = sum_ai; res.store_value = s1_b;
        end
        OP_J: begin
          res.jump_taken = 1'b1; res.jump_target = sum_pi;
        end
        OP_JAL: begin
          res.jump_taken = 1'b1; res.jump_target = sum_pi;
          wb_req = 1'b1; wb_addr = 5'd1; wb_data = link;
        end
        OP_BEQZ: begin
          if (s1_a == '0) begin
            res.jump_taken = 1'b1; res.jump_target = sum_pi;
          end
        end
        OP_BNEZ: begin
          if (s1_a != '0) begin
            res.jump_taken = 1'b1; res.jump_target = sum_pi;
          end
        end
        OP_JR: begin
          res.jump_taken = 1'b1; res.jump_target = s1_a & JR_MASK;
        end
        OP_JALR: begin
          res.jump_taken = 1'b1; res.jump_target = s1_a & JR_MASK;
          wb_req = 1'b1; wb_addr = 5'd1; wb_data = link;
        end
        OP_EBRK: begin
          res.status = ST_BREAK;
        end
        OP_FLW: begin
          res.mem_kind = MK_FLW; res.mem_address = sum_ai; res.fp_reg = s1_item.dest_reg;
        end
        OP_FLD: begin
          res.mem_kind = MK_FLD; res.mem_address = sum_ai; res.fp_reg = s1_item.dest_reg;
        end
        OP_FSW: begin
          res.mem_kind = MK_FSW; res.mem_address = sum_ai; res.fp_reg = s1_item.src2_reg;
        end
        OP_FSD: begin
          res.mem_kind = MK_FSD; res.mem_address = sum_ai; res.fp_reg = s1_item.src2_reg;
        end
        default: begin
          res.status = ST_UNSUPPORTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wb_addr[REG_AW-1:0]] <= wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (wr_en) begin
      reg_valid[wb_addr[REG_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_item;
      s1_mode <= s_axis_tuser[0];
      s1_a    <= rd1_next;
      s1_b    <= rd2_next;
    end
    if (commit) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      pending_load_dest <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
      if (commit) begin
        pending_load_dest <= pending_load_dest_next;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item;

endmodule

`default_nettype wire

// ----- hdl/rv32c_execute_unit_chk.sv -----
// port-level checker for rv32c_execute_unit, attached by bind
// depends on rv32c_pkg and rv32c_execute_unit_assert.svh
`default_nettype none

`include "rv32c_execute_unit_assert.svh"

module rv32c_execute_unit_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [rv32c_pkg::OUT_W-1:0] m_axis_tdata
);
  import rv32c_pkg::*;

  out_item_t o;
  logic      out_stall;
  logic      out_special;
  logic      out_no_req;

  assign o           = out_item_t'(m_axis_tdata);
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_special = m_axis_tvalid && o.status != ST_DONE;
  assign out_no_req  = m_axis_tvalid && o.mem_kind == MK_NONE;

  `RV32C_ASSERT_NEXT(out_held, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `RV32C_ASSERT_NOW(ready_only_on_stall, !s_axis_tready, out_stall)
  `RV32C_ASSERT_NOW(status_excl, out_special, !o.jump_taken && o.mem_kind == MK_NONE)
  `RV32C_ASSERT_NOW(target_zero, m_axis_tvalid && !o.jump_taken, o.jump_target == '0)
  `RV32C_ASSERT_NOW(no_request_zero, out_no_req, (o.mem_address | o.store_value) == '0 && o.fp_reg == '0)

endmodule

bind rv32c_execute_unit rv32c_execute_unit_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- dv/rv32c_execute_unit_tb.sv -----
// self-checking testbench for rv32c_execute_unit: directed and random operation streams
// with load returns, checked against an in-bench register file and pending-load model
// depends on rv32c_pkg and rv32c_execute_unit
`default_nettype none

module rv32c_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rv32c_pkg::*;

  localparam logic [4:0] LINK_REG = 5'd1;

  class exec_scoreboard;
    logic [31:0] xreg [REG_COUNT];
    logic [4:0]  load_dest;
    out_item_t   result_q [$];
    int          errors;

    function new();
      foreach (xreg[i]) xreg[i] = '0;
      load_dest = '0;
      errors = 0;
    endfunction

    function logic [31:0] read_x(logic [4:0] idx);
      if (idx == 0 || idx >= REG_COUNT) return '0;
      return xreg[idx];
    endfunction

    function void write_x(logic [4:0] idx, logic [31:0] val);
      if (idx != 0 && idx < REG_COUNT) xreg[idx] = val;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void note_input(logic mode, in_item_t it);
      out_item_t   r;
      logic [31:0] a, b, imm, link, tgt;
      logic [4:0]  sh;
      r = '0;
      a = read_x(it.src1_reg);
      b = read_x(it.src2_reg);
      imm = it.imm_value;
      sh = imm[4:0];
      link = it.pc_value + 32'(it.inst_length);
      tgt = it.pc_value + imm;
      if (mode == MODE_LOAD) begin
        if (!it.load_fault) write_x(load_dest, it.load_value);
      end else begin
        case (it.operation)
          OP_NOP: begin end
          OP_ADDI: write_x(it.dest_reg, a + imm);
          OP_LI:   write_x(it.dest_reg, imm);
          OP_SRLI: write_x(it.dest_reg, a >> sh);
          OP_SRAI: write_x(it.dest_reg, $unsigned($signed(a) >>> sh));
          OP_ANDI: write_x(it.dest_reg, a & imm);
          OP_SUB:  write_x(it.dest_reg, a - b);
          OP_XOR:  write_x(it.dest_reg, a ^ b);
          OP_OR:   write_x(it.dest_reg, a | b);
          OP_AND:  write_x(it.dest_reg, a & b);
          OP_SLLI: write_x(it.dest_reg, a << sh);
          OP_MV:   write_x(it.dest_reg, b);
          OP_ADD:  write_x(it.dest_reg, a + b);
          OP_LW: begin
            r.mem_kind = MK_LW;
            r.mem_address = a + imm;
            load_dest = it.dest_reg;
          end
          OP_SW: begin
            r.mem_kind = MK_SW;
            r.mem_address = a + imm;
            r.store_value = b;
          end
          OP_J: begin
            r.jump_taken = 1'b1;
            r.jump_target = tgt;
          end
          OP_JAL: begin
            write_x(LINK_REG, link);
            r.jump_taken = 1'b1;
            r.jump_target = tgt;
          end
          OP_BEQZ: if (a == 0) begin
            r.jump_taken = 1'b1;
            r.jump_target = tgt;
          end
          OP_BNEZ: if (a != 0) begin
            r.jump_taken = 1'b1;
            r.jump_target = tgt;
          end
          OP_JR: begin
            r.jump_taken = 1'b1;
            r.jump_target = a & JR_MASK;
          end
          OP_JALR: begin
            r.jump_taken = 1'b1;
            r.jump_target = a & JR_MASK;
            write_x(LINK_REG, link);
          end
          OP_EBRK: r.status = ST_BREAK;
          OP_FLW: begin
            r.mem_kind = MK_FLW;
            r.mem_address = a + imm;
            r.fp_reg = it.dest_reg;
          end
          OP_FLD: begin
            r.mem_kind = MK_FLD;
            r.mem_address = a + imm;
            r.fp_reg = it.dest_reg;
          end
          OP_FSW: begin
            r.mem_kind = MK_FSW;
            r.mem_address = a + imm;
            r.fp_reg = it.src2_reg;
          end
          OP_FSD: begin
            r.mem_kind = MK_FSD;
            r.mem_address = a + imm;
            r.fp_reg = it.src2_reg;
          end
          default: r.status = ST_UNSUPPORTED;
        endcase
      end
      result_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (result_q.size() == 0) begin
        $error("result transfer with no expectation waiting");
        errors++;
        return;
      end
      want = result_q.pop_front();
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("jump_taken", 32'(want.jump_taken), 32'(got.jump_taken));
      cmp_field("jump_target", want.jump_target, got.jump_target);
      cmp_field("mem_kind", 32'(want.mem_kind), 32'(got.mem_kind));
      cmp_field("mem_address", want.mem_address, got.mem_address);
      cmp_field("store_value", want.store_value, got.store_value);
      cmp_field("fp_reg", 32'(want.fp_reg), 32'(got.fp_reg));
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;

  exec_scoreboard sb = new();
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  load_waiting = 1'b0;

  rv32c_execute_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(out_item_t'(m_axis_tdata));
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send(input logic mode, input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    s_axis_tuser <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(mode, it);
  endtask

  task automatic exec_item(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] rs1,
                           input logic [4:0] rs2, input logic [31:0] imm,
                           input logic [2:0] len = 3'd4, input logic [31:0] pc = $urandom);
    in_item_t it;
    it.operation = op;
    it.dest_reg = rd;
    it.src1_reg = rs1;
    it.src2_reg = rs2;
    it.imm_value = imm;
    it.inst_length = len;
    it.pc_value = pc;
    it.load_value = $urandom;
    it.load_fault = 1'($urandom_range(1));
    send(MODE_EXEC, it);
  endtask

  task automatic load_return(input logic [31:0] val, input logic fault);
    in_item_t it;
    it.operation = 5'($urandom_range(31));
    it.dest_reg = 5'($urandom_range(31));
    it.src1_reg = 5'($urandom_range(31));
    it.src2_reg = 5'($urandom_range(31));
    it.imm_value = $urandom;
    it.inst_length = 3'($urandom_range(2, 4));
    it.pc_value = $urandom;
    it.load_value = val;
    it.load_fault = fault;
    send(MODE_LOAD, it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [4:0] rand_reg();
    if ($urandom_range(3) != 0) return 5'($urandom_range(7));
    return 5'($urandom_range(31));
  endfunction

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(4))
      0, 1: return $urandom;
      2: return $urandom_range(63) - 32;
      3: return $urandom_range(31);
      default: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  task automatic random_step();
    in_item_t it;
    logic     mode;
    int       r;
    it.operation = 5'($urandom_range(OP_FSD));
    it.dest_reg = rand_reg();
    it.src1_reg = rand_reg();
    it.src2_reg = rand_reg();
    it.imm_value = rand_imm();
    it.inst_length = 3'($urandom_range(2, 4));
    it.pc_value = ($urandom_range(3) == 0) ? rand_imm() : $urandom;
    it.load_value = ($urandom_range(7) == 0) ? rand_imm() : $urandom;
    it.load_fault = ($urandom_range(7) == 0);
    r = $urandom_range(99);
    if (r < 5) it.operation = 5'($urandom_range(31, OP_FSD + 1));
    else if (r < 18) it.operation = OP_LI;
    else if (r < 26) it.operation = OP_LW;
    mode = MODE_EXEC;
    if (load_waiting && $urandom_range(99) < 60) mode = MODE_LOAD;
    else if ($urandom_range(99) < 3) mode = MODE_LOAD;
    if (mode == MODE_LOAD) load_waiting = 1'b0;
    else if (it.operation == OP_LW) load_waiting = 1'b1;
    send(mode, it);
  endtask

  initial begin
    int idle_tbl [4] = '{0, 62, 0, 7};
    int stall_tbl [4] = '{0, 0, 62, 7};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // stray load return right after reset lands on x0
    load_return(32'hffff_ffff, 1'b0);
    exec_item(OP_LI, 5'd0, 5'd3, 5'd4, 32'h1234_5678);
    exec_item(OP_LI, 5'd1, 5'd0, 5'd0, 32'h7fff_ffff);
    exec_item(OP_LI, 5'd2, 5'd0, 5'd0, 32'h8000_0000);
    exec_item(OP_LI, 5'd31, 5'd0, 5'd0, 32'hffff_ffff);
    exec_item(OP_SRAI, 5'd3, 5'd2, 5'd0, 32'hffff_ffff);
    exec_item(OP_SRLI, 5'd4, 5'd2, 5'd0, 32'hffff_ffe0);
    exec_item(OP_SLLI, 5'd5, 5'd31, 5'd0, 32'd31);
    exec_item(OP_ADDI, 5'd6, 5'd1, 5'd0, 32'd1);
    exec_item(OP_ANDI, 5'd7, 5'd31, 5'd0, 32'h8000_0000);
    exec_item(OP_SUB, 5'd8, 5'd0, 5'd1, 32'd0);
    exec_item(OP_XOR, 5'd9, 5'd1, 5'd2, 32'd0);
    exec_item(OP_OR, 5'd10, 5'd2, 5'd6, 32'd0);
    exec_item(OP_AND, 5'd11, 5'd31, 5'd1, 32'd0);
    exec_item(OP_MV, 5'd12, 5'd0, 5'd31, 32'd0);
    exec_item(OP_ADD, 5'd13, 5'd1, 5'd2, 32'd0);
    exec_item(OP_LW, 5'd14, 5'd2, 5'd0, 32'hffff_fffc);
    load_return(32'h5a5a_a5a5, 1'b1);
    exec_item(OP_LW, 5'd15, 5'd1, 5'd0, 32'd1);
    load_return(32'h0f0f_f0f0, 1'b0);
    exec_item(OP_SW, 5'd0, 5'd15, 5'd15, 32'h7fff_ffff);
    exec_item(OP_J, 5'd0, 5'd0, 5'd0, 32'd4, 3'd2, 32'hffff_fffe);
    exec_item(OP_JAL, 5'd0, 5'd0, 5'd0, 32'hffff_fffe, 3'd3, 32'hffff_ffff);
    exec_item(OP_BEQZ, 5'd0, 5'd0, 5'd0, 32'h8000_0000);
    exec_item(OP_BEQZ, 5'd0, 5'd31, 5'd0, 32'd8);
    exec_item(OP_BNEZ, 5'd0, 5'd31, 5'd0, 32'hffff_fff0);
    exec_item(OP_BNEZ, 5'd0, 5'd0, 5'd0, 32'd8);
    exec_item(OP_JR, 5'd0, 5'd31, 5'd0, 32'd0);
    exec_item(OP_JALR, 5'd0, 5'd1, 5'd0, 32'd0, 3'd2);
    exec_item(OP_EBRK, 5'd0, 5'd0, 5'd0, 32'd0);
    exec_item(OP_FLW, 5'd31, 5'd2, 5'd0, 32'd4);
    exec_item(OP_FLD, 5'd0, 5'd31, 5'd0, 32'hffff_fff8);
    exec_item(OP_FSW, 5'd0, 5'd1, 5'd31, 32'd0);
    exec_item(OP_FSD, 5'd0, 5'd0, 5'd7, 32'h7fff_fff8);
    exec_item('1, 5'd5, 5'd1, 5'd2, 32'd0);
    exec_item(OP_NOP, 5'd31, 5'd31, 5'd31, 32'hffff_ffff);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tbl[p];
      stall_pct = stall_tbl[p];
      for (int n = 0; n < 350; n++) random_step();
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/rv32c_pkg.sv
hdl/rv32c_execute_unit.sv
hdl/rv32c_execute_unit_chk.sv
dv/rv32c_execute_unit_tb.sv
